>>> sv/tte_pkg.sv
package tte_pkg;

	// Screen geometry
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int ADDR_W  = $clog2(CELLS);

	// Field widths
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CELL_W = 16;

	// Control bytes
	localparam logic [7:0] BYTE_ESC   = 8'd27;
	localparam logic [7:0] BYTE_LF    = 8'd10;
	localparam logic [7:0] BYTE_CR    = 8'd13;
	localparam logic [7:0] BYTE_SPACE = 8'h20;

	// Escape command letters
	localparam logic [7:0] CMD_GOTO   = 8'h47; // G
	localparam logic [7:0] CMD_UP     = 8'h55; // U
	localparam logic [7:0] CMD_DOWN   = 8'h44; // D
	localparam logic [7:0] CMD_RIGHT  = 8'h52; // R
	localparam logic [7:0] CMD_ATTR   = 8'h41; // A
	localparam logic [7:0] CMD_BELL   = 8'h42; // B
	localparam logic [7:0] CMD_STYLE  = 8'h43; // C
	localparam logic [7:0] CMD_CLS    = 8'h53; // S
	localparam logic [7:0] CMD_CLRLN  = 8'h4C; // L

	// Cursor style codes
	localparam logic [7:0] STYLE_HIDDEN = 8'd2;
	localparam logic [7:0] STYLE_HALF   = 8'd3;
	localparam logic [7:0] STYLE_BLOCK  = 8'd4;

	// Reset values
	localparam logic [7:0] ATTR_RESET  = 8'd7;
	localparam logic [7:0] TONE_RESET  = 8'd1;
	localparam logic [7:0] LEN_RESET   = 8'd10;
	localparam logic [7:0] STYLE_RESET = 8'd128;

	// Parser phases
	typedef enum logic [2:0] {
		PH_TEXT  = 3'd0,
		PH_ESC   = 3'd1,
		PH_COL   = 3'd2,
		PH_ROW   = 3'd3,
		PH_ATTR  = 3'd4,
		PH_TONE  = 3'd5,
		PH_LEN   = 3'd6,
		PH_STYLE = 3'd7
	} phase_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic clr_step;
		logic load_out;
	} tte_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_start;
		logic clr_last;
	} tte_stat_t;

endpackage

>>> sv/text_terminal_escape_engine.sv
// Character terminal over an 80 x 25 screen store of attribute/character cells.
// Input channel (in_valid / in_stall): req_type 0 sends a host byte in
// char_byte, req_type 1 reads the cell at read_address. Each transfer gives
// exactly one result on the output channel (out_valid / out_stall): the read
// cell (zero for bytes or addresses off the screen), the cursor, the cursor
// start scan line and the bell settings.
// An accepted item updates the terminal state and the registered read of the
// screen store; the result is then loaded into the output register, and no
// new item is taken before that load. Clear screen walks the store at one
// cell per cycle over all 2000 cells; clear to end of line walks the cells
// from the cursor to the row end. in_stall is high while an item is in work.
// A finished result waits in the output register while out_stall is high; the
// next item is still taken and its result is held back until that one leaves.
// Reset clears the cursor, parser and settings but not the screen store, so
// the host clears the screen before reading cells.
module text_terminal_escape_engine
	import tte_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              req_type,
	input  logic [7:0]        char_byte,
	input  logic [10:0]       read_address,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CELL_W-1:0] cell_value,
	output logic [COL_W-1:0]  cursor_column,
	output logic [ROW_W-1:0]  cursor_row,
	output logic [5:0]        cursor_top_line,
	output logic              bell_ring,
	output logic              bell_sweep,
	output logic [11:0]       bell_frequency,
	output logic [9:0]        bell_duration_ms
);

	tte_cmd_t  cmd;
	tte_stat_t stat;

	tte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	tte_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.req_type        (req_type),
		.char_byte       (char_byte),
		.read_address    (read_address),
		.cell_value      (cell_value),
		.cursor_column   (cursor_column),
		.cursor_row      (cursor_row),
		.cursor_top_line (cursor_top_line),
		.bell_ring       (bell_ring),
		.bell_sweep      (bell_sweep),
		.bell_frequency  (bell_frequency),
		.bell_duration_ms(bell_duration_ms)
	);

endmodule

>>> sv/tte_ram.sv
module tte_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/tte_ctrl.sv
module tte_ctrl
	import tte_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  tte_stat_t stat,
	output tte_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	// Commands
	always_comb begin
		cmd.accept   = (state_q == ST_IDLE) && in_valid;
		cmd.clr_step = (state_q == ST_CLEAR);
		cmd.load_out = (state_q == ST_DONE) && out_free;
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Sequence each item and hold the result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= stat.clr_start ? ST_CLEAR : ST_DONE;
					end
				end
				ST_CLEAR: begin
					if (stat.clr_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && out_stall))
		else $error("result overwritten while stalled");

	// No item is taken while a clear is in progress
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !cmd.accept)
		else $error("item accepted during clear");

	// A clear always ends in a result
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && stat.clr_last) |=> (state_q == ST_DONE))
		else $error("clear did not finish into result");

endmodule

>>> sv/tte_datapath.sv
module tte_datapath
	import tte_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  tte_cmd_t          cmd,
	output tte_stat_t         stat,
	input  logic              req_type,
	input  logic [7:0]        char_byte,
	input  logic [10:0]       read_address,
	output logic [CELL_W-1:0] cell_value,
	output logic [COL_W-1:0]  cursor_column,
	output logic [ROW_W-1:0]  cursor_row,
	output logic [5:0]        cursor_top_line,
	output logic              bell_ring,
	output logic              bell_sweep,
	output logic [11:0]       bell_frequency,
	output logic [9:0]        bell_duration_ms
);

	// Terminal state
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [7:0]       attr_q;
	phase_t           phase_q;
	logic [7:0]       tone_q;
	logic [7:0]       len_q;
	logic [7:0]       style_q;
	logic             ring_q;
	logic             rd_hit_q;
	logic [ADDR_W-1:0] clr_idx_q;
	logic [ADDR_W-1:0] clr_end_q;

	// Result registers
	logic [CELL_W-1:0] cell_q;
	logic [COL_W-1:0]  ocol_q;
	logic [ROW_W-1:0]  orow_q;
	logic [5:0]        otop_q;
	logic              oring_q;
	logic              osweep_q;
	logic [11:0]       ofreq_q;
	logic [9:0]        odur_q;

	// Next-state values
	logic [COL_W-1:0] n_col;
	logic [ROW_W-1:0] n_row;
	logic [7:0]       n_attr;
	phase_t           n_phase;
	logic [7:0]       n_tone;
	logic [7:0]       n_len;
	logic [7:0]       n_style;
	logic             n_ring;
	logic             do_print;
	logic             clr_all;
	logic             clr_line;

	logic [ROW_W-1:0]  row_inc;
	logic [COL_W-1:0]  col_set;
	logic [ROW_W-1:0]  row_set;
	logic [ADDR_W-1:0] row_base;
	logic [ADDR_W-1:0] cell_idx;
	logic [5:0]        top_line;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [CELL_W-1:0] ram_rdata;

	// Cursor cell address
	assign row_base = ADDR_W'(row_q) * ADDR_W'(COLUMNS);
	assign cell_idx = row_base + ADDR_W'(col_q);

	assign row_inc = (row_q == ROW_W'(ROWS - 1)) ? '0 : row_q + 1'b1;

	// 1-based positions, clamped to the last column or row
	assign col_set = (char_byte == 8'd0 || char_byte > 8'(COLUMNS)) ?
		COL_W'(COLUMNS - 1) : COL_W'(char_byte - 8'd1);
	assign row_set = (char_byte == 8'd0 || char_byte > 8'(ROWS)) ?
		ROW_W'(ROWS - 1) : ROW_W'(char_byte - 8'd1);

	// Decode one host byte
	always_comb begin
		n_col    = col_q;
		n_row    = row_q;
		n_attr   = attr_q;
		n_phase  = phase_q;
		n_tone   = tone_q;
		n_len    = len_q;
		n_style  = style_q;
		n_ring   = 1'b0;
		do_print = 1'b0;
		clr_all  = 1'b0;
		clr_line = 1'b0;
		if (!req_type) begin
			case (phase_q)
				PH_TEXT: begin
					if (char_byte == BYTE_ESC) begin
						n_phase = PH_ESC;
					end else if (char_byte == BYTE_LF) begin
						n_col = '0;
						n_row = row_inc;
					end else if (char_byte == BYTE_CR) begin
						n_col = '0;
					end else begin
						do_print = 1'b1;
					end
				end
				PH_ESC: begin
					n_phase = PH_TEXT;
					case (char_byte)
						CMD_GOTO:  n_phase = PH_COL;
						CMD_UP: begin
							if (row_q != '0) n_row = row_q - 1'b1;
						end
						CMD_DOWN: begin
							if (row_q != ROW_W'(ROWS - 1)) n_row = row_q + 1'b1;
						end
						CMD_RIGHT: begin
							if (col_q != COL_W'(COLUMNS - 1)) n_col = col_q + 1'b1;
						end
						CMD_ATTR:  n_phase = PH_ATTR;
						CMD_BELL:  n_phase = PH_TONE;
						CMD_STYLE: n_phase = PH_STYLE;
						CMD_CLS: begin
							clr_all = 1'b1;
							n_col   = '0;
							n_row   = '0;
						end
						CMD_CLRLN: clr_line = 1'b1;
						default:   do_print = 1'b1;
					endcase
				end
				PH_COL: begin
					n_col   = col_set;
					n_phase = PH_ROW;
				end
				PH_ROW: begin
					n_row   = row_set;
					n_phase = PH_TEXT;
				end
				PH_ATTR: begin
					n_attr  = char_byte;
					n_phase = PH_TEXT;
				end
				PH_TONE: begin
					n_tone  = char_byte;
					n_phase = PH_LEN;
				end
				PH_LEN: begin
					n_len   = char_byte;
					n_ring  = 1'b1;
					n_phase = PH_TEXT;
				end
				PH_STYLE: begin
					n_style = char_byte;
					n_phase = PH_TEXT;
				end
				default: n_phase = PH_TEXT;
			endcase
			// Advance after a printed byte, wrapping at the row end
			if (do_print) begin
				if (col_q == COL_W'(COLUMNS - 1)) begin
					n_col = '0;
					n_row = row_inc;
				end else begin
					n_col = col_q + 1'b1;
				end
			end
		end
	end

	assign stat.clr_start = clr_all || clr_line;
	assign stat.clr_last  = (clr_idx_q == clr_end_q);

	// Update terminal state on each transfer and walk a clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			attr_q   <= ATTR_RESET;
			phase_q  <= PH_TEXT;
			tone_q   <= TONE_RESET;
			len_q    <= LEN_RESET;
			style_q  <= STYLE_RESET;
			ring_q   <= 1'b0;
			rd_hit_q <= 1'b0;
		end else if (cmd.accept) begin
			col_q    <= n_col;
			row_q    <= n_row;
			attr_q   <= n_attr;
			phase_q  <= n_phase;
			tone_q   <= n_tone;
			len_q    <= n_len;
			style_q  <= n_style;
			ring_q   <= n_ring;
			rd_hit_q <= req_type && (int'(read_address) < CELLS);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && clr_all) begin
			clr_idx_q <= '0;
			clr_end_q <= ADDR_W'(CELLS - 1);
		end else if (cmd.accept && clr_line) begin
			clr_idx_q <= cell_idx;
			clr_end_q <= row_base + ADDR_W'(COLUMNS - 1);
		end else if (cmd.clr_step) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	// Screen store
	assign ram_we    = (cmd.accept && do_print) || cmd.clr_step;
	assign ram_waddr = cmd.clr_step ? clr_idx_q : cell_idx;
	assign ram_wdata = cmd.clr_step ? {attr_q, BYTE_SPACE} : {attr_q, char_byte};

	tte_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.accept && req_type),
		.raddr(ADDR_W'(read_address)),
		.rdata(ram_rdata)
	);

	// Cursor start scan line from the style code
	always_comb begin
		case (style_q)
			STYLE_HIDDEN: top_line = 6'd32;
			STYLE_HALF:   top_line = 6'd7;
			STYLE_BLOCK:  top_line = 6'd0;
			default:      top_line = 6'd5;
		endcase
	end

	// Load the result
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			cell_q   <= rd_hit_q ? ram_rdata : '0;
			ocol_q   <= col_q;
			orow_q   <= row_q;
			otop_q   <= top_line;
			oring_q  <= ring_q;
			osweep_q <= (tone_q == 8'd3) && (len_q == 8'd3);
			ofreq_q  <= 12'(tone_q) * 12'd10;
			odur_q   <= 10'(len_q) * 10'd3;
		end
	end

	assign cell_value       = cell_q;
	assign cursor_column    = ocol_q;
	assign cursor_row       = orow_q;
	assign cursor_top_line  = otop_q;
	assign bell_ring        = oring_q;
	assign bell_sweep       = osweep_q;
	assign bell_frequency   = ofreq_q;
	assign bell_duration_ms = odur_q;

	// Cursor always stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(col_q) < COLUMNS) && (int'(row_q) < ROWS))
		else $error("cursor off screen");

	// Clear walk never passes its end
	a_clear_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> (clr_idx_q <= clr_end_q))
		else $error("clear walk past end");

	// Bell rings only after the duration byte
	a_ring_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ring_q) |-> ($past(phase_q) == PH_LEN))
		else $error("bell outside bell sequence");

	// Parser holds between transfers
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cmd.accept) |-> $stable(phase_q))
		else $error("parser moved without a transfer");

endmodule
